// ===== design/fpcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fpcl_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Loading modes; any code above fast passive parallel acts as secure
  localparam logic [1:0] MODE_PS  = 2'd0;
  localparam logic [1:0] MODE_FPP = 2'd1;

  // Status codes of a result beat
  localparam logic [2:0] ST_PROGRESS = 3'd0;
  localparam logic [2:0] ST_SUCCESS  = 3'd1;
  localparam logic [2:0] ST_NSTATUS  = 3'd2;
  localparam logic [2:0] ST_NOT_DONE = 3'd3;
  localparam logic [2:0] ST_SEQUENCE = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE            = 2'd0;
  localparam logic [1:0] REG_NCONFIG_LOW     = 2'd1;
  localparam logic [1:0] REG_CONFIG_TO_CLOCK = 2'd2;
  localparam logic [1:0] REG_DONE_WAIT       = 2'd3;

  // Configuration reset values
  localparam logic [1:0]  MODE_RESET            = MODE_PS;
  localparam logic [15:0] NCONFIG_LOW_RESET     = 16'd5;
  localparam logic [15:0] CONFIG_TO_CLOCK_RESET = 16'd100;
  localparam logic [15:0] DONE_WAIT_RESET       = 16'd100;

  // Remaining units after the first one of a byte
  localparam logic [2:0] SERIAL_MORE_BITS    = 3'd7;
  localparam logic [2:0] FPP_MORE_PULSES     = 3'd0;
  localparam logic [2:0] SECURE_EXTRA_CLOCKS = 3'd3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef enum logic [2:0] {
    CMD_START      = 3'd0,
    CMD_BYTE       = 3'd1,
    CMD_FINISH     = 3'd2,
    CMD_ERR_SEQ    = 3'd3,
    CMD_ERR_STATUS = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       serial;
    logic [2:0] pulses;
    logic [7:0] data_byte;
    logic       conf_done;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] nconfig_low_us;
    logic [15:0] config_to_clock_us;
    logic [15:0] done_wait_us;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

// ===== design/fpcl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input item channel
interface fpcl_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       status_ok;
  logic       conf_done;

  modport source (output valid, operation, data_byte, status_ok, conf_done, input ready);
  modport sink   (input valid, operation, data_byte, status_ok, conf_done, output ready);
endinterface

// Result (pin state) channel
interface fpcl_result_if;
  logic        valid;
  logic        ready;
  logic        nconfig_level;
  logic        dclk_level;
  logic [7:0]  data_pins;
  logic [15:0] hold_us;
  logic        abort_pulse;
  logic [2:0]  status_code;
  logic        last;

  modport source (output valid, nconfig_level, dclk_level, data_pins, hold_us, abort_pulse,
                  status_code, last, input ready);
  modport sink   (input valid, nconfig_level, dclk_level, data_pins, hold_us, abort_pulse,
                  status_code, last, output ready);
endinterface
`default_nettype wire

// ===== design/fpcl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fpcl_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          mode,
  fpcl_item_if.sink                item,
  input  wire fpcl_pkg::queue_stat_t q_stat,
  output logic                     push,
  output fpcl_pkg::cmd_t           push_cmd
);
  import fpcl_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_STARTED = 3'b010,
    PH_LOADING = 3'b100
  } phase_t;

  phase_t phase;
  phase_t phase_next;

  // Take a beat whenever the queue has room
  assign item.ready = !q_stat.full;
  assign push       = item.valid && item.ready;

  // Classify the item against the loading phase
  always_comb begin
    phase_next         = phase;
    push_cmd.kind      = CMD_ERR_SEQ;
    push_cmd.serial    = (mode == MODE_PS);
    push_cmd.data_byte = item.data_byte;
    push_cmd.conf_done = item.conf_done;
    priority case (mode)
      MODE_PS:  push_cmd.pulses = SERIAL_MORE_BITS;
      MODE_FPP: push_cmd.pulses = FPP_MORE_PULSES;
      default:  push_cmd.pulses = SECURE_EXTRA_CLOCKS;
    endcase
    unique case (item.operation)
      OP_START: begin
        push_cmd.kind = CMD_START;
        phase_next    = PH_STARTED;
      end
      OP_BYTE: begin
        if (phase == PH_IDLE) begin
          push_cmd.kind = CMD_ERR_SEQ;
        end else if (!item.status_ok) begin
          push_cmd.kind = CMD_ERR_STATUS;
          phase_next    = PH_IDLE;
        end else begin
          push_cmd.kind = CMD_BYTE;
          phase_next    = PH_LOADING;
        end
      end
      OP_FINISH: begin
        push_cmd.kind = (phase == PH_LOADING) ? CMD_FINISH : CMD_ERR_SEQ;
        phase_next    = PH_IDLE;
      end
      default: begin
        push_cmd.kind = CMD_ERR_SEQ;
      end
    endcase
  end

  // Advance the phase on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (push) begin
      phase <= phase_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/fpcl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fpcl_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire fpcl_pkg::cmd_t      push_cmd,
  input  wire logic                pop,
  output fpcl_pkg::cmd_t           head,
  output fpcl_pkg::queue_stat_t    stat
);
  import fpcl_pkg::*;

  localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == FULL_COUNT);
  assign stat.empty = (count == '0);

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/fpcl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fpcl_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire fpcl_pkg::cfg_t        cfg,
  input  wire fpcl_pkg::cmd_t        head,
  input  wire fpcl_pkg::queue_stat_t q_stat,
  output logic                       pop,
  fpcl_result_if.source              result
);
  import fpcl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_START0 = 10'b00_0000_0010,
    S_START1 = 10'b00_0000_0100,
    S_START2 = 10'b00_0000_1000,
    S_SET    = 10'b00_0001_0000,
    S_HI     = 10'b00_0010_0000,
    S_LO     = 10'b00_0100_0000,
    S_FIN0   = 10'b00_1000_0000,
    S_FIN1   = 10'b01_0000_0000,
    S_ONE    = 10'b10_0000_0000
  } seq_state_t;

  seq_state_t state;
  seq_state_t st_cur;
  seq_state_t state_next;
  cmd_t       cmd_reg;
  cmd_t       cmd_cur;
  logic [2:0] cnt;
  logic [2:0] cnt_cur;
  logic [2:0] cnt_next;
  logic [7:0] shreg;
  logic [7:0] sh_cur;
  logic [7:0] sh_next;
  logic       idle;
  logic       go;

  // Held pin levels
  logic       nconfig_held;
  logic       dclk_held;
  logic [7:0] held_data;

  // Beat under construction
  logic        b_nconfig;
  logic        b_dclk;
  logic [7:0]  b_data;
  logic [15:0] b_hold;
  logic        b_abort;
  logic [2:0]  b_status;
  logic        b_last;

  // When idle, the queue head starts at once so no cycle is lost between items
  assign idle    = (state == S_IDLE);
  assign cmd_cur = idle ? head : cmd_reg;
  assign cnt_cur = idle ? head.pulses : cnt;
  assign sh_cur  = idle ? head.data_byte : shreg;
  assign go      = (!idle || !q_stat.empty) && (!result.valid || result.ready);
  assign pop     = go && idle;

  // Pick the step for the current beat
  always_comb begin
    if (idle) begin
      unique case (head.kind)
        CMD_START:  st_cur = S_START0;
        CMD_BYTE:   st_cur = S_SET;
        CMD_FINISH: st_cur = S_FIN0;
        default:    st_cur = S_ONE;
      endcase
    end else begin
      st_cur = state;
    end
  end

  // Build the pin state of this step
  always_comb begin
    b_nconfig  = nconfig_held;
    b_dclk     = dclk_held;
    b_data     = held_data;
    b_hold     = '0;
    b_abort    = 1'b0;
    b_status   = ST_PROGRESS;
    b_last     = 1'b0;
    state_next = st_cur;
    cnt_next   = cnt_cur;
    sh_next    = sh_cur;
    unique case (st_cur)
      S_START0: begin
        b_nconfig  = 1'b0;
        b_hold     = cfg.nconfig_low_us;
        state_next = S_START1;
      end
      S_START1: begin
        b_nconfig  = 1'b1;
        b_hold     = cfg.config_to_clock_us;
        state_next = S_START2;
      end
      S_START2: begin
        b_dclk = 1'b0;
        b_last = 1'b1;
      end
      S_SET: begin
        b_data     = cmd_cur.serial ? {7'b0, sh_cur[0]} : sh_cur;
        sh_next    = {1'b0, sh_cur[7:1]};
        state_next = S_HI;
      end
      S_HI: begin
        b_dclk     = 1'b1;
        state_next = S_LO;
      end
      S_LO: begin
        b_dclk = 1'b0;
        if (cnt_cur == '0) begin
          b_last = 1'b1;
        end else begin
          cnt_next   = cnt_cur - 1'b1;
          state_next = cmd_cur.serial ? S_SET : S_HI;
        end
      end
      S_FIN0: begin
        b_dclk     = 1'b1;
        b_hold     = cfg.done_wait_us;
        state_next = S_FIN1;
      end
      S_FIN1: begin
        b_abort  = !cmd_cur.conf_done;
        b_status = cmd_cur.conf_done ? ST_SUCCESS : ST_NOT_DONE;
        b_last   = 1'b1;
      end
      S_ONE: begin
        b_abort  = (cmd_cur.kind == CMD_ERR_STATUS);
        b_status = (cmd_cur.kind == CMD_ERR_STATUS) ? ST_NSTATUS : ST_SEQUENCE;
        b_last   = 1'b1;
      end
      default: begin
        b_last = 1'b1;
      end
    endcase
  end

  // Advance the sequencer and the held pins
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      nconfig_held <= 1'b1;
      dclk_held    <= 1'b0;
      held_data    <= '0;
    end else if (go) begin
      state        <= b_last ? S_IDLE : state_next;
      nconfig_held <= b_nconfig;
      dclk_held    <= b_dclk;
      held_data    <= b_data;
    end
  end

  // Hold the working copy of the command
  always_ff @(posedge clk) begin
    if (go) begin
      cnt   <= cnt_next;
      shreg <= sh_next;
      if (idle) begin
        cmd_reg <= head;
      end
    end
  end

  // Output register: load a beat, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result.nconfig_level <= b_nconfig;
      result.dclk_level    <= b_dclk;
      result.data_pins     <= b_data;
      result.hold_us       <= b_hold;
      result.abort_pulse   <= b_abort;
      result.status_code   <= b_status;
      result.last          <= b_last;
    end
  end

endmodule
`default_nettype wire

// ===== design/fpga_passive_config_loader_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An item is registered in the command queue and its first pin-state beat in the output
// register. The back-end sequencer gives one beat per cycle while the result is taken
// and commands are queued: a serial byte 24 beats, a parallel byte 3, a secure one 9,
// start 3, finish 2 and an error 1. A two-deep queue holds items while beats drain.
// Reset (synchronous, active high): phase idle, nCONFIG held high, DCLK low, data zero,
// registers to their defaults, queue and output register empty.
module fpga_passive_config_loader_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  fpcl_item_if.sink        item,
  fpcl_result_if.source    result
);
  import fpcl_pkg::*;

  cfg_t        cfg;
  cmd_t        push_cmd;
  cmd_t        head;
  queue_stat_t q_stat;
  logic        push;
  logic        pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode               <= MODE_RESET;
      cfg.nconfig_low_us     <= NCONFIG_LOW_RESET;
      cfg.config_to_clock_us <= CONFIG_TO_CLOCK_RESET;
      cfg.done_wait_us       <= DONE_WAIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:            cfg.mode               <= cfg_data[1:0];
        REG_NCONFIG_LOW:     cfg.nconfig_low_us     <= cfg_data;
        REG_CONFIG_TO_CLOCK: cfg.config_to_clock_us <= cfg_data;
        REG_DONE_WAIT:       cfg.done_wait_us       <= cfg_data;
        default:             cfg.mode               <= cfg.mode;
      endcase
    end
  end

  fpcl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .mode     (cfg.mode),
    .item     (item),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  fpcl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  fpcl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .result (result)
  );

  // An accepted item is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  // An abort only closes an item, with an nSTATUS or CONF_DONE failure
  a_abort_closes: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.abort_pulse) |->
      (result.last && (result.status_code == ST_NSTATUS ||
                       result.status_code == ST_NOT_DONE)))
    else $error("abort beat malformed");

  // A final status is only reported on the closing beat
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status_code != ST_PROGRESS) |-> result.last)
    else $error("status on a non-final beat");

  // No beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== tb/fpcl_pin_checker.sv =====
`timescale 1ns / 1ps
module fpcl_pin_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  fpcl_item_if        item,
  fpcl_result_if      result,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import fpcl_pkg::*;

  typedef enum logic [1:0] {
    LD_IDLE    = 2'd0,
    LD_STARTED = 2'd1,
    LD_LOADING = 2'd2
  } load_phase_t;

  typedef struct packed {
    logic        nconfig;
    logic        dclk;
    logic [7:0]  data;
    logic [15:0] hold;
    logic        abrt;
    logic [2:0]  status;
    logic        last;
  } pin_beat_t;

  // Own copy of the registers and of the pin state
  logic [1:0]  cfg_mode;
  logic [15:0] cfg_nconfig_low;
  logic [15:0] cfg_to_clock;
  logic [15:0] cfg_done_wait;
  load_phase_t ld_phase;
  logic [7:0]  pin_data;
  logic        pin_nconfig;
  logic        pin_dclk;

  pin_beat_t pin_state_q[$];
  int mismatches;
  int beats_checked;

  // Queue one pin state built from the held levels
  task automatic push_pin_state(input logic [15:0] hold, input logic abrt,
                                input logic [2:0] status, input logic last);
    pin_beat_t b;
    b.nconfig = pin_nconfig;
    b.dclk    = pin_dclk;
    b.data    = pin_data;
    b.hold    = hold;
    b.abrt    = abrt;
    b.status  = status;
    b.last    = last;
    pin_state_q.push_back(b);
  endtask

  // Work out the pin sequence that one accepted item causes
  task automatic predict_pin_states(input logic [1:0] op, input logic [7:0] dbyte,
                                    input logic ok, input logic done);
    int pulses;
    case (op)
      OP_START: begin
        pin_nconfig = 1'b0;
        push_pin_state(cfg_nconfig_low, 1'b0, ST_PROGRESS, 1'b0);
        pin_nconfig = 1'b1;
        push_pin_state(cfg_to_clock, 1'b0, ST_PROGRESS, 1'b0);
        pin_dclk = 1'b0;
        push_pin_state(16'd0, 1'b0, ST_PROGRESS, 1'b1);
        ld_phase = LD_STARTED;
      end
      OP_BYTE: begin
        if (ld_phase == LD_IDLE) begin
          push_pin_state(16'd0, 1'b0, ST_SEQUENCE, 1'b1);
        end else if (!ok) begin
          ld_phase = LD_IDLE;
          push_pin_state(16'd0, 1'b1, ST_NSTATUS, 1'b1);
        end else begin
          if (cfg_mode == MODE_PS) begin
            // Serial: LSB first, one clock pulse per bit
            for (int i = 0; i < 8; i++) begin
              pin_data = {7'd0, dbyte[i]};
              push_pin_state(16'd0, 1'b0, ST_PROGRESS, 1'b0);
              pin_dclk = 1'b1;
              push_pin_state(16'd0, 1'b0, ST_PROGRESS, 1'b0);
              pin_dclk = 1'b0;
              push_pin_state(16'd0, 1'b0, ST_PROGRESS, i == 7);
            end
          end else begin
            // Parallel: whole byte, extra pulses in secure and reserved modes
            pulses = (cfg_mode == MODE_FPP) ? 1 : 1 + SECURE_EXTRA_CLOCKS;
            pin_data = dbyte;
            push_pin_state(16'd0, 1'b0, ST_PROGRESS, 1'b0);
            for (int j = 0; j < pulses; j++) begin
              pin_dclk = 1'b1;
              push_pin_state(16'd0, 1'b0, ST_PROGRESS, 1'b0);
              pin_dclk = 1'b0;
              push_pin_state(16'd0, 1'b0, ST_PROGRESS, j == pulses - 1);
            end
          end
          ld_phase = LD_LOADING;
        end
      end
      OP_FINISH: begin
        if (ld_phase != LD_LOADING) begin
          push_pin_state(16'd0, 1'b0, ST_SEQUENCE, 1'b1);
        end else begin
          pin_dclk = 1'b1;
          push_pin_state(cfg_done_wait, 1'b0, ST_PROGRESS, 1'b0);
          push_pin_state(16'd0, !done, done ? ST_SUCCESS : ST_NOT_DONE, 1'b1);
        end
        ld_phase = LD_IDLE;
      end
      default: begin
        push_pin_state(16'd0, 1'b0, ST_SEQUENCE, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Compare result beats, track register writes, predict on input beats
  always @(posedge clk) begin
    pin_beat_t want;
    if (rst) begin
      cfg_mode        = MODE_RESET;
      cfg_nconfig_low = NCONFIG_LOW_RESET;
      cfg_to_clock    = CONFIG_TO_CLOCK_RESET;
      cfg_done_wait   = DONE_WAIT_RESET;
      ld_phase        = LD_IDLE;
      pin_data        = 8'd0;
      pin_nconfig     = 1'b1;
      pin_dclk        = 1'b0;
      pin_state_q.delete();
      mismatches      = 0;
      beats_checked   = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (pin_state_q.size() == 0) begin
          $error("pin-state beat with nothing expected");
          mismatches++;
        end else begin
          want = pin_state_q.pop_front();
          check_field("nconfig_level", 16'(want.nconfig), 16'(result.nconfig_level));
          check_field("dclk_level", 16'(want.dclk), 16'(result.dclk_level));
          check_field("data_pins", 16'(want.data), 16'(result.data_pins));
          check_field("hold_us", want.hold, result.hold_us);
          check_field("abort_pulse", 16'(want.abrt), 16'(result.abort_pulse));
          check_field("status_code", 16'(want.status), 16'(result.status_code));
          check_field("last", 16'(want.last), 16'(result.last));
          beats_checked++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:            cfg_mode        = cfg_data[1:0];
          REG_NCONFIG_LOW:     cfg_nconfig_low = cfg_data;
          REG_CONFIG_TO_CLOCK: cfg_to_clock    = cfg_data;
          REG_DONE_WAIT:       cfg_done_wait   = cfg_data;
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        predict_pin_states(item.operation, item.data_byte, item.status_ok, item.conf_done);
      end
    end
    fail_count <= mismatches;
    pending    <= pin_state_q.size();
    checked    <= beats_checked;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import fpcl_pkg::*;

  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_TAIL   = 4;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int tx_idle_pct = 8;
  int rx_idle_pct = 60;
  int stall_req_count = 0;
  int items_sent = 0;

  fpcl_item_if   item();
  fpcl_result_if result();

  fpga_passive_config_loader_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result)
  );

  fpcl_pin_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  // Drive ready: random idling, plus a long hold-off on request
  initial begin : rx_drive
    int stall_left;
    int stall_served;
    stall_left   = 0;
    stall_served = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_served != stall_req_count) begin
        stall_served = stall_req_count;
        stall_left   = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one item, idling at random first, and hold until taken
  task automatic send_item(input logic [1:0] op, input logic [7:0] dbyte,
                           input logic ok, input logic done);
    while ($urandom_range(99) < tx_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid     <= 1'b1;
    item.operation <= op;
    item.data_byte <= dbyte;
    item.status_ok <= ok;
    item.conf_done <= done;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic wait_drained();
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Write all four registers; noise in the unused mode bits
  task automatic write_regs(input logic [1:0] mode_v, input logic [15:0] nlow,
                            input logic [15:0] c2c, input logic [15:0] dwait);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= {14'($urandom), mode_v};
    @(posedge clk);
    cfg_index <= REG_NCONFIG_LOW;
    cfg_data  <= nlow;
    @(posedge clk);
    cfg_index <= REG_CONFIG_TO_CLOCK;
    cfg_data  <= c2c;
    @(posedge clk);
    cfg_index <= REG_DONE_WAIT;
    cfg_data  <= dwait;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed load sequences, the rest single noise items
  task automatic run_random(input int count);
    int stop_at;
    int nbytes;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        send_item(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
        nbytes = $urandom_range(1, 6);
        repeat (nbytes) begin
          send_item(OP_BYTE, 8'($urandom), $urandom_range(19) != 0, 1'($urandom));
        end
        send_item(OP_FINISH, 8'($urandom), 1'($urandom), $urandom_range(9) != 0);
      end else begin
        send_item(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_MODE;
    cfg_data       <= 16'd0;
    item.valid     <= 1'b0;
    item.operation <= OP_START;
    item.data_byte <= 8'd0;
    item.status_ok <= 1'b0;
    item.conf_done <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset register values, serial mode
    send_item(OP_BYTE, 8'hFF, 1'b1, 1'b1);     // byte while idle
    send_item(OP_FINISH, 8'h00, 1'b1, 1'b1);   // finish while idle
    send_item(2'd3, 8'hFF, 1'b1, 1'b1);        // unknown operation
    send_item(OP_START, 8'h00, 1'b0, 1'b0);
    send_item(OP_FINISH, 8'h00, 1'b1, 1'b1);   // finish before any byte
    send_item(OP_START, 8'hFF, 1'b1, 1'b1);
    send_item(OP_BYTE, 8'h00, 1'b1, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b1, 1'b0);
    send_item(2'd3, 8'h00, 1'b0, 1'b0);        // unknown operation mid-load
    send_item(OP_BYTE, 8'hA5, 1'b1, 1'b0);
    send_item(OP_FINISH, 8'h00, 1'b1, 1'b1);   // success
    send_item(OP_START, 8'h00, 1'b1, 1'b1);
    send_item(OP_START, 8'h00, 1'b1, 1'b1);    // restart while busy
    send_item(OP_BYTE, 8'h5A, 1'b0, 1'b1);     // nSTATUS error
    send_item(OP_BYTE, 8'h5A, 1'b1, 1'b1);     // byte after abort
    send_item(OP_START, 8'h00, 1'b1, 1'b1);
    send_item(OP_BYTE, 8'h3C, 1'b1, 1'b1);
    send_item(OP_FINISH, 8'hFF, 1'b1, 1'b0);   // CONF_DONE low
    wait_drained();

    // Sender idles lightly, receiver heavily; long hold-off fills the block
    write_regs(MODE_FPP, 16'd0, 16'd0, 16'd0);
    stall_req_count <= stall_req_count + 1;
    run_random(25);
    wait_drained();
    write_regs(2'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(25);
    wait_drained();

    // Sender idles heavily, receiver lightly
    tx_idle_pct = 60;
    rx_idle_pct = 8;
    write_regs(2'd3, 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(25);
    wait_drained();
    write_regs(MODE_PS, 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(20);
    // Pause the sender until everything has come back, same settings
    wait_drained();
    run_random(12);
    wait_drained();

    // No idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_regs(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(35);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d items and checked %0d pin-state beats in all four mode codes,",
             items_sent, checked);
    $display("with register extremes, a %0d-cycle receiver hold-off and drained pauses.",
             STALL_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("fpga_passive_config_loader_top test passed");
    end else begin
      $display("fpga_passive_config_loader_top test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("fpga_passive_config_loader_top test failed");
    $finish;
  end

endmodule
